FILE: hdl/lfg_pkg.sv
package lfg_pkg;

  // Strip size default and fixed field widths
  localparam int CELL_COUNT_DEF = 64;
  localparam int HEAT_W         = 8;
  localparam int LFSR_W         = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;
  localparam int IN_DATA_W      = 8;
  localparam int OUT_DATA_W     = 32;
  localparam int PIX_IDX_W      = 6;

  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

  // Register reset values
  localparam logic [7:0]  COOLING_SPAN_RST   = 8'd2;
  localparam logic [7:0]  SPARK_CHANCE_RST   = 8'd140;
  localparam logic [6:0]  SPARK_ZONE_RST     = 7'd28;
  localparam logic [7:0]  SPARK_HEAT_MIN_RST = 8'd120;
  localparam logic [7:0]  SPARK_HEAT_MAX_RST = 8'd255;
  localparam logic [1:0]  PALETTE_RST        = 2'd1;
  localparam logic [15:0] LFSR_SEED_RST      = 16'd44257;

  // Spark roll range
  localparam logic [7:0] ROLL_RANGE = 8'd255;

  // Palette thresholds and fixed levels
  localparam logic [7:0] T_HOT     = 8'd128;
  localparam logic [7:0] T_WARM    = 8'd64;
  localparam logic [7:0] LVL_FULL  = 8'd255;
  localparam logic [7:0] LVL_GREEN = 8'd200;
  localparam logic [7:0] LVL_BLUE  = 8'd100;
  localparam logic [7:0] LVL_DIM   = 8'd20;
  localparam logic [7:0] LVL_GLOW  = 8'd5;
  localparam logic [7:0] LVL_OFF   = 8'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COOLING_SPAN   = 3'd0,
    REG_SPARK_CHANCE   = 3'd1,
    REG_SPARK_ZONE     = 3'd2,
    REG_SPARK_HEAT_MIN = 3'd3,
    REG_SPARK_HEAT_MAX = 3'd4,
    REG_PALETTE        = 3'd5,
    REG_LFSR_SEED      = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PAL_GREEN = 2'd0,
    PAL_RED   = 2'd1,
    PAL_BLUE  = 2'd2,
    PAL_OFF   = 2'd3
  } pal_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COOL,
    ST_DIFF,
    ST_ROLL,
    ST_CELL,
    ST_HEAT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // One right-shifting Galois step
  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] r);
    logic [LFSR_W-1:0] s;
    s = {1'b0, r[LFSR_W-1:1]};
    if (r[0]) begin
      s = s ^ LFSR_TAPS;
    end
    return s;
  endfunction

  // Scale a fresh LFSR value onto 0..n-1
  function automatic logic [7:0] draw(input logic [LFSR_W-1:0] r, input logic [7:0] n);
    logic [23:0] p;
    p = 24'(r) * 24'(n);
    return p[23:16];
  endfunction

  // Exact floor(s/3) for s up to 765: multiply by 683, drop 11 bits
  function automatic logic [7:0] div3(input logic [9:0] s);
    logic [19:0] p;
    p = 20'(s) * 20'd683;
    return p[18:11];
  endfunction

  function automatic rgb_t colour(input logic [7:0] heat, input pal_t pal);
    logic [15:0] scaled;
    logic [15:0] q;
    logic [7:0]  t;
    logic [7:0]  ramp;
    rgb_t        c;
    // t = (heat*191 + 127) / 255, divide done as (x + 1 + x>>8) >> 8
    scaled = 16'(heat) * 16'd191 + 16'd127;
    q      = (scaled + 16'd1 + (scaled >> 8)) >> 8;
    t      = q[7:0];
    ramp   = {t[5:0], 2'b00};
    if (pal == PAL_OFF) begin
      c = '{LVL_OFF, LVL_OFF, LVL_OFF};
    end else if (t > T_HOT) begin
      c = '{LVL_FULL, LVL_FULL, ramp};
    end else if (t > T_WARM) begin
      case (pal)
        PAL_GREEN: c = '{LVL_GREEN, LVL_GREEN, ramp};
        PAL_RED:   c = '{LVL_FULL, ramp, LVL_OFF};
        default:   c = '{LVL_BLUE, ramp, LVL_FULL};
      endcase
    end else begin
      case (pal)
        PAL_GREEN: c = '{LVL_DIM, ramp, LVL_GLOW};
        PAL_RED:   c = '{ramp, LVL_OFF, LVL_OFF};
        default:   c = '{LVL_DIM, LVL_DIM, ramp};
      endcase
    end
    return c;
  endfunction

endpackage

FILE: hdl/lfg_heat_ram.sv
module lfg_heat_ram #(
  parameter int DEPTH  = lfg_pkg::CELL_COUNT_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic [lfg_pkg::HEAT_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [ADDR_W-1:0]         rd_addr,
  output logic [lfg_pkg::HEAT_W-1:0] rd_data
);

  logic [lfg_pkg::HEAT_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]           vld_r;
  logic [lfg_pkg::HEAT_W-1:0] q_r;
  logic                       q_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  // Per-entry written flags: an unwritten cell reads as cold
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      q_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        q_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = q_vld_r ? q_r : '0;

endmodule

FILE: hdl/led_fire_effect_generator_core.sv
// Channel   Dir  Handshake              Payload
// in_       in   in_tvalid/in_tready    in_tdata[0] advance (1 steps, 0 re-emits)
// out_      out  out_tvalid/out_tready  out_tdata pixel + RGB, out_tlast frame end
// cfg_      in   cfg_wr_en              cfg_index register, cfg_wdata value
//
// Each input word yields CELL_COUNT pixel words, bottom cell first.
// Re-emit and frame-tick time are set by the single read port of the heat
// memory (a frame tick runs cool, diffuse and emit sweeps; re-emit only emit).
// Synchronous active-low reset restores control and registers to defaults and
// clears heat (by flags). Output stalls hold the emit sweep; the last pixel
// may wait while in_ takes the next word.
module led_fire_effect_generator_core #(
  parameter int CELL_COUNT = lfg_pkg::CELL_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // [0] advance, [7:1] zero
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [lfg_pkg::IN_DATA_W-1:0]  in_tdata,
  // [5:0] pixel_index, [13:6] red_level, [21:14] green_level,
  // [29:22] blue_level, [31:30] zero
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [lfg_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tlast,
  input  logic                           cfg_wr_en,
  input  logic [lfg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lfg_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] DIFF_TOP  = ADDR_W'(CELL_COUNT - 2);
  localparam logic [6:0]        ZONE_MAX  = 7'(CELL_COUNT);

  // Configuration registers
  logic [7:0]           cooling_span_r;
  logic [7:0]           spark_chance_r;
  logic [6:0]           spark_zone_r;
  logic [7:0]           spark_heat_min_r;
  logic [7:0]           spark_heat_max_r;
  lfg_pkg::pal_t        palette_r;
  logic                 seed_wr;
  logic [15:0]          seed_val;

  // Sequencer
  lfg_pkg::state_t      state_r, state_nxt;
  logic [ADDR_W-1:0]    cnt_r, cnt_nxt;
  logic                 iss_done_r, iss_done_nxt;
  logic                 pend_r, pend_nxt;
  logic [ADDR_W-1:0]    pend_addr_r;
  logic [7:0]           prev_r, prev_nxt;
  logic [15:0]          lfsr_r, lfsr_nxt;
  logic                 issue;
  logic                 consume;
  logic                 load_out;

  // Heat memory port
  logic                 rd_en;
  logic [ADDR_W-1:0]    rd_addr;
  logic [7:0]           rd_heat;
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  logic [7:0]           wr_data;

  // Datapath
  logic [15:0]          lfsr_adv;
  logic [7:0]           cool_amt;
  logic [7:0]           cooled;
  logic [9:0]           diff_sum;
  logic [7:0]           diff_val;
  logic [7:0]           roll;
  logic [6:0]           zone;
  logic [7:0]           cell_pick;
  logic [7:0]           spark_amt;
  logic [8:0]           spark_sum;
  logic [7:0]           spark_val;
  lfg_pkg::rgb_t        pix_rgb;

  // Output register
  logic                 out_valid_r;
  logic [ADDR_W-1:0]    out_idx_r;
  lfg_pkg::rgb_t        out_rgb_r;
  logic                 out_last_r;

  //--------------------------------------------------------------------------
  // Configuration
  //--------------------------------------------------------------------------
  assign seed_wr  = cfg_wr_en && (lfg_pkg::cfg_reg_t'(cfg_index) == lfg_pkg::REG_LFSR_SEED);
  // A zero seed would lock the LFSR: load one instead
  assign seed_val = (cfg_wdata == '0) ? 16'd1 : cfg_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cooling_span_r   <= lfg_pkg::COOLING_SPAN_RST;
      spark_chance_r   <= lfg_pkg::SPARK_CHANCE_RST;
      spark_zone_r     <= lfg_pkg::SPARK_ZONE_RST;
      spark_heat_min_r <= lfg_pkg::SPARK_HEAT_MIN_RST;
      spark_heat_max_r <= lfg_pkg::SPARK_HEAT_MAX_RST;
      palette_r        <= lfg_pkg::pal_t'(lfg_pkg::PALETTE_RST);
    end else if (cfg_wr_en) begin
      case (lfg_pkg::cfg_reg_t'(cfg_index))
        lfg_pkg::REG_COOLING_SPAN:   cooling_span_r   <= cfg_wdata[7:0];
        lfg_pkg::REG_SPARK_CHANCE:   spark_chance_r   <= cfg_wdata[7:0];
        lfg_pkg::REG_SPARK_ZONE:     spark_zone_r     <= cfg_wdata[6:0];
        lfg_pkg::REG_SPARK_HEAT_MIN: spark_heat_min_r <= cfg_wdata[7:0];
        lfg_pkg::REG_SPARK_HEAT_MAX: spark_heat_max_r <= cfg_wdata[7:0];
        lfg_pkg::REG_PALETTE:        palette_r        <= lfg_pkg::pal_t'(cfg_wdata[1:0]);
        default: ;
      endcase
    end
  end

  //--------------------------------------------------------------------------
  // Heat memory
  //--------------------------------------------------------------------------
  lfg_heat_ram #(
    .DEPTH  (CELL_COUNT),
    .ADDR_W (ADDR_W)
  ) u_heat_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_heat)
  );

  //--------------------------------------------------------------------------
  // Arithmetic on the word coming out of the memory
  //--------------------------------------------------------------------------
  assign lfsr_adv  = lfg_pkg::lfsr_step(lfsr_r);

  // Cooling: a zero span draws zero, still stepping the LFSR
  assign cool_amt  = lfg_pkg::draw(lfsr_adv, cooling_span_r);
  assign cooled    = (cool_amt > rd_heat) ? 8'd0 : rd_heat - cool_amt;

  // Diffusion: prev_r holds cell k-1, the fresh read is cell k-2
  assign diff_sum  = 10'(prev_r) + {1'b0, rd_heat, 1'b0};
  assign diff_val  = lfg_pkg::div3(diff_sum);

  assign roll      = lfg_pkg::draw(lfsr_adv, lfg_pkg::ROLL_RANGE);
  assign zone      = (spark_zone_r > ZONE_MAX) ? ZONE_MAX : spark_zone_r;
  assign cell_pick = lfg_pkg::draw(lfsr_adv, {1'b0, zone});

  // Spark heat: an empty range gives the minimum
  assign spark_amt = (spark_heat_max_r > spark_heat_min_r)
                   ? spark_heat_min_r
                     + lfg_pkg::draw(lfsr_adv, spark_heat_max_r - spark_heat_min_r)
                   : spark_heat_min_r;
  assign spark_sum = {1'b0, rd_heat} + {1'b0, spark_amt};
  assign spark_val = spark_sum[8] ? 8'hFF : spark_sum[7:0];

  assign pix_rgb   = lfg_pkg::colour(rd_heat, palette_r);

  //--------------------------------------------------------------------------
  // Sequencer: one sweep of the heat memory per cool, diffuse and emit phase
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= lfg_pkg::ST_IDLE;
      cnt_r      <= '0;
      iss_done_r <= 1'b0;
      pend_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      iss_done_r <= iss_done_nxt;
      pend_r     <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r <= lfg_pkg::LFSR_SEED_RST;
    end else if (seed_wr) begin
      lfsr_r <= seed_val;
    end else begin
      lfsr_r <= lfsr_nxt;
    end
  end

  // Track which cell the registered read data belongs to
  always_ff @(posedge clk) begin
    if (rd_en) begin
      pend_addr_r <= rd_addr;
    end
    prev_r <= prev_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    iss_done_nxt = iss_done_r;
    lfsr_nxt     = lfsr_r;
    prev_nxt     = prev_r;
    issue        = 1'b0;
    consume      = 1'b0;
    load_out     = 1'b0;
    in_tready    = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = cnt_r;
    wr_en        = 1'b0;
    wr_addr      = pend_addr_r;
    wr_data      = cooled;

    case (state_r)
      lfg_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt    = in_tdata[0] ? lfg_pkg::ST_COOL : lfg_pkg::ST_EMIT;
          cnt_nxt      = '0;
          iss_done_nxt = 1'b0;
        end
      end

      // Cool cells bottom up: read one cell while writing back the previous
      lfg_pkg::ST_COOL: begin
        issue   = !iss_done_r;
        consume = pend_r;
        rd_en   = issue;
        if (pend_r) begin
          lfsr_nxt = lfsr_adv;
          wr_en    = 1'b1;
          wr_data  = cooled;
        end
        if (iss_done_r && pend_r) begin
          state_nxt    = lfg_pkg::ST_DIFF;
          cnt_nxt      = DIFF_TOP;
          iss_done_nxt = 1'b0;
        end
      end

      // Diffuse top down: read cell j, write cell j+2 from j+1 and j
      lfg_pkg::ST_DIFF: begin
        issue   = !iss_done_r;
        consume = pend_r;
        rd_en   = issue;
        if (pend_r) begin
          prev_nxt = rd_heat;
          if (pend_addr_r != DIFF_TOP) begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(pend_addr_r + ADDR_W'(2));
            wr_data = diff_val;
          end
        end
        if (iss_done_r && pend_r) begin
          state_nxt = lfg_pkg::ST_ROLL;
        end
      end

      lfg_pkg::ST_ROLL: begin
        lfsr_nxt = lfsr_adv;
        if (roll < spark_chance_r) begin
          state_nxt = lfg_pkg::ST_CELL;
        end else begin
          state_nxt    = lfg_pkg::ST_EMIT;
          cnt_nxt      = '0;
          iss_done_nxt = 1'b0;
        end
      end

      // Pick the spark cell and fetch its heat
      lfg_pkg::ST_CELL: begin
        lfsr_nxt  = lfsr_adv;
        rd_en     = 1'b1;
        rd_addr   = cell_pick[ADDR_W-1:0];
        state_nxt = lfg_pkg::ST_HEAT;
      end

      lfg_pkg::ST_HEAT: begin
        lfsr_nxt     = lfsr_adv;
        wr_en        = 1'b1;
        wr_data      = spark_val;
        state_nxt    = lfg_pkg::ST_EMIT;
        cnt_nxt      = '0;
        iss_done_nxt = 1'b0;
      end

      // Emit: read data waits in the memory output register while stalled
      lfg_pkg::ST_EMIT: begin
        load_out = pend_r && (!out_valid_r || out_tready);
        issue    = !iss_done_r && (!pend_r || load_out);
        consume  = load_out;
        rd_en    = issue;
        if (load_out && (pend_addr_r == LAST_ADDR)) begin
          state_nxt = lfg_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = lfg_pkg::ST_IDLE;
      end
    endcase

    // Advance the sweep address; diffusion walks downward
    if (issue) begin
      if (state_r == lfg_pkg::ST_DIFF) begin
        if (cnt_r == '0) begin
          iss_done_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r - ADDR_W'(1);
        end
      end else begin
        if (cnt_r == LAST_ADDR) begin
          iss_done_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r + ADDR_W'(1);
        end
      end
    end
  end

  assign pend_nxt = issue ? 1'b1 : (consume ? 1'b0 : pend_r);

  //--------------------------------------------------------------------------
  // Output register
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_idx_r  <= pend_addr_r;
      out_rgb_r  <= pix_rgb;
      out_last_r <= (pend_addr_r == LAST_ADDR);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_rgb_r.blue, out_rgb_r.green, out_rgb_r.red,
                       lfg_pkg::PIX_IDX_W'(out_idx_r)};

endmodule

FILE: hdl/lfg_checker.sv
module lfg_checker #(
  parameter int CELL_COUNT = lfg_pkg::CELL_COUNT_DEF
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [lfg_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tlast
);

  localparam logic [lfg_pkg::PIX_IDX_W-1:0] LAST_IDX = lfg_pkg::PIX_IDX_W'(CELL_COUNT - 1);

  // Busy after taking a word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken twice in a row");

  // Mid-frame pixel pending means the frame is not finished
  a_no_accept_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input ready while frame incomplete");

  // Frame end sits on the top cell
  a_last_on_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[lfg_pkg::PIX_IDX_W-1:0] == LAST_IDX)
    else $error("frame end on wrong pixel");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled pixel changed");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("pixel valid out of reset");

endmodule

bind led_fire_effect_generator_core lfg_checker #(
  .CELL_COUNT (CELL_COUNT)
) u_lfg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
